FILE: rtl/lls_pkg.sv
// Shared types and constants of the least-loaded server selector.
package lls_pkg;

  localparam int IdW      = 6;
  localparam int DeltaW   = 16;
  localparam int LoadW    = 32;
  localparam int CfgW     = 7;
  localparam int CfgReset = 64;

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_UP,
    DIR_DOWN
  } dir_e;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [DeltaW-1:0] delta;
    logic              bad;
    dir_e              dir;
  } item_t;

  typedef struct packed {
    logic  empty;
    item_t head;
  } queue_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLOT,
    ST_NODE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_L,
    ST_DN_R,
    ST_DN_CMP,
    ST_PLACE,
    ST_ROOT,
    ST_OUT
  } state_e;

endpackage

FILE: rtl/least_loaded_server_selector.sv
// Top level of the least-loaded server selector: count register, front end and heap engine.
//
//   channel   signals                                   accepted when
//   input     start, busy, server_id_i, load_delta_i    start high and busy low
//   result    result_valid_o, least_id_o, least_load_o,  the cycle result_valid_o is high
//             bad_id_o
//   config    cfg_valid_i, cfg_ready_o, cfg_data_i      cfg_valid_i and cfg_ready_o high
//
// A query reads its slot and node before the root is read, and a rejected id goes straight
// to the root read. An update also climbs or descends the heap level by level, bounded by
// the single read port of the heap memory.
// After reset and after each count write, a clearing pass over all MAX_SERVER_COUNT entries
// rewrites both memories while busy stays high. A two-entry queue takes items while the
// heap engine works. Results cannot be stalled and appear for one cycle each.
module least_loaded_server_selector #(
  parameter int MAX_SERVER_COUNT = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [lls_pkg::IdW-1:0]      server_id_i,
  input  logic [lls_pkg::DeltaW-1:0]   load_delta_i,
  output logic                         result_valid_o,
  output logic [lls_pkg::IdW-1:0]      least_id_o,
  output logic [lls_pkg::LoadW-1:0]    least_load_o,
  output logic                         bad_id_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lls_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int CW = $clog2(MAX_SERVER_COUNT + 1);
  localparam int ResetCount = (lls_pkg::CfgReset > MAX_SERVER_COUNT) ? MAX_SERVER_COUNT
                                                                     : lls_pkg::CfgReset;

  logic [CW-1:0]   count_q, count_d;
  logic            cfg_wr;
  logic            pop;
  logic            clearing;
  lls_pkg::queue_t queue;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    count_d = count_q;
    if (cfg_wr) begin
      if (cfg_data_i == '0) begin
        count_d = CW'(1);
      end else if (32'(cfg_data_i) > MAX_SERVER_COUNT) begin
        count_d = CW'(MAX_SERVER_COUNT);
      end else begin
        count_d = CW'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CW'(ResetCount);
    end else begin
      count_q <= count_d;
    end
  end

  lls_front #(.CNT_W(CW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .server_id_i  (server_id_i),
    .load_delta_i (load_delta_i),
    .count_i      (count_q),
    .clearing_i   (clearing),
    .pop_i        (pop),
    .busy_o       (busy),
    .queue_o      (queue)
  );

  lls_back #(.MAX_SERVER_COUNT(MAX_SERVER_COUNT), .CNT_W(CW)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_i       (cfg_wr),
    .count_i        (count_q),
    .queue_i        (queue),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .result_valid_o (result_valid_o),
    .least_id_o     (least_id_o),
    .least_load_o   (least_load_o),
    .bad_id_o       (bad_id_o)
  );

endmodule

FILE: rtl/lls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lls_front.sv
// Front end: accepts items, checks the id, classifies the change and queues the item.
module lls_front #(
  parameter int CNT_W = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [lls_pkg::IdW-1:0]  server_id_i,
  input  logic [lls_pkg::DeltaW-1:0] load_delta_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic                     clearing_i,
  input  logic                     pop_i,
  output logic                     busy_o,
  output lls_pkg::queue_t          queue_o
);

  lls_pkg::item_t mem_q [2];
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     fill_q, fill_d;
  logic           push;
  lls_pkg::item_t item;

  always_comb begin
    item.id    = server_id_i;
    item.delta = load_delta_i;
    item.bad   = (32'(server_id_i) >= 32'(count_i));
    if (load_delta_i == '0) begin
      item.dir = lls_pkg::DIR_NONE;
    end else if (load_delta_i[lls_pkg::DeltaW-1]) begin
      item.dir = lls_pkg::DIR_UP;
    end else begin
      item.dir = lls_pkg::DIR_DOWN;
    end
  end

  assign busy_o = (fill_q == 2'd2) || clearing_i;
  assign push   = start_i && !busy_o;

  always_comb begin
    wptr_d = push ? !wptr_q : wptr_q;
    rptr_d = pop_i ? !rptr_q : rptr_q;
    fill_d = fill_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= item;
    end
  end

  assign queue_o.empty = (fill_q == 2'd0);
  assign queue_o.head  = mem_q[rptr_q];

endmodule

FILE: rtl/lls_back.sv
// Back end: updates a load, sifts the heap in memory and reports the root.
module lls_back #(
  parameter int MAX_SERVER_COUNT = 64,
  parameter int CNT_W = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_i,
  input  logic [CNT_W-1:0]           count_i,
  input  lls_pkg::queue_t            queue_i,
  output logic                       pop_o,
  output logic                       clearing_o,
  output logic                       result_valid_o,
  output logic [lls_pkg::IdW-1:0]    least_id_o,
  output logic [lls_pkg::LoadW-1:0]  least_load_o,
  output logic                       bad_id_o
);

  localparam int IW = $clog2(MAX_SERVER_COUNT);
  localparam int NW = IW + lls_pkg::LoadW;

  typedef struct packed {
    logic [IW-1:0]             id;
    logic [lls_pkg::LoadW-1:0] load;
  } node_t;

  function automatic logic precedes(node_t a, node_t b);
    logic lt;
    logic eq;
    lt = $signed(a.load) < $signed(b.load);
    eq = a.load == b.load;
    return lt || (eq && (a.id < b.id));
  endfunction

  lls_pkg::state_e state_q, state_d;
  lls_pkg::item_t  item_q, item_d;
  logic [IW-1:0]   slot_q, slot_d;
  node_t           node_q, node_d;
  node_t           lnode_q, lnode_d;
  logic [IW-1:0]   clr_q, clr_d;
  logic            res_v_q, res_v_d;
  logic [lls_pkg::IdW-1:0]   res_id_q, res_id_d;
  logic [lls_pkg::LoadW-1:0] res_load_q, res_load_d;
  logic            res_bad_q, res_bad_d;

  logic            heap_we, slot_we;
  logic [IW-1:0]   heap_waddr, heap_raddr, slot_waddr, slot_raddr;
  node_t           heap_wdata, heap_rdata;
  logic [IW-1:0]   slot_wdata, slot_rdata;

  logic [IW+1:0]   l_idx, r_idx, cnt_ext;
  logic [IW-1:0]   p_idx;
  logic [IW+5:0]   id_ext;
  logic [IW+5:0]   head_ext;
  logic [IW+5:0]   root_ext;
  logic signed [lls_pkg::LoadW:0] sum;
  node_t           upd, best_n;
  logic [IW-1:0]   best_i;
  logic            best_self;

  lls_ram #(.WIDTH(NW), .DEPTH(MAX_SERVER_COUNT)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rdata)
  );

  lls_ram #(.WIDTH(IW), .DEPTH(MAX_SERVER_COUNT)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  assign l_idx   = (IW + 2)'({slot_q, 1'b1});
  assign r_idx   = l_idx + 1'b1;
  assign cnt_ext = (IW + 2)'(count_i);
  assign p_idx   = (slot_q - 1'b1) >> 1;
  assign id_ext  = {{IW{1'b0}}, item_q.id};
  assign head_ext = {{IW{1'b0}}, queue_i.head.id};
  assign root_ext = {6'd0, heap_rdata.id};

  always_comb begin
    sum = $signed({heap_rdata.load[lls_pkg::LoadW-1], heap_rdata.load})
        + $signed({{(lls_pkg::LoadW - lls_pkg::DeltaW + 1){item_q.delta[lls_pkg::DeltaW-1]}},
                   item_q.delta});
    upd.id = heap_rdata.id;
    if (sum[lls_pkg::LoadW] != sum[lls_pkg::LoadW-1]) begin
      upd.load = sum[lls_pkg::LoadW] ? {1'b1, {(lls_pkg::LoadW-1){1'b0}}}
                                     : {1'b0, {(lls_pkg::LoadW-1){1'b1}}};
    end else begin
      upd.load = sum[lls_pkg::LoadW-1:0];
    end
  end

  always_comb begin
    best_n    = node_q;
    best_i    = slot_q;
    best_self = 1'b1;
    if (precedes(lnode_q, node_q)) begin
      best_n    = lnode_q;
      best_i    = l_idx[IW-1:0];
      best_self = 1'b0;
    end
    if ((r_idx < cnt_ext) && precedes(heap_rdata, best_n)) begin
      best_n    = heap_rdata;
      best_i    = r_idx[IW-1:0];
      best_self = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lls_pkg::ST_CLEAR: begin
        if (clr_q == IW'(MAX_SERVER_COUNT - 1)) begin
          state_d = lls_pkg::ST_IDLE;
        end
      end
      lls_pkg::ST_IDLE: begin
        if (!queue_i.empty) begin
          state_d = queue_i.head.bad ? lls_pkg::ST_ROOT : lls_pkg::ST_SLOT;
        end
      end
      lls_pkg::ST_SLOT: state_d = lls_pkg::ST_NODE;
      lls_pkg::ST_NODE: begin
        case (item_q.dir)
          lls_pkg::DIR_UP:   state_d = lls_pkg::ST_UP_RD;
          lls_pkg::DIR_DOWN: state_d = lls_pkg::ST_DN_L;
          default:           state_d = lls_pkg::ST_ROOT;
        endcase
      end
      lls_pkg::ST_UP_RD: begin
        state_d = (slot_q == '0) ? lls_pkg::ST_PLACE : lls_pkg::ST_UP_CMP;
      end
      lls_pkg::ST_UP_CMP: begin
        state_d = precedes(node_q, heap_rdata) ? lls_pkg::ST_UP_RD : lls_pkg::ST_PLACE;
      end
      lls_pkg::ST_DN_L: begin
        state_d = (l_idx >= cnt_ext) ? lls_pkg::ST_PLACE : lls_pkg::ST_DN_R;
      end
      lls_pkg::ST_DN_R:   state_d = lls_pkg::ST_DN_CMP;
      lls_pkg::ST_DN_CMP: state_d = best_self ? lls_pkg::ST_PLACE : lls_pkg::ST_DN_L;
      lls_pkg::ST_PLACE:  state_d = lls_pkg::ST_ROOT;
      lls_pkg::ST_ROOT:   state_d = lls_pkg::ST_OUT;
      lls_pkg::ST_OUT:    state_d = lls_pkg::ST_IDLE;
      default:            state_d = lls_pkg::ST_IDLE;
    endcase
    if (cfg_wr_i) begin
      state_d = lls_pkg::ST_CLEAR;
    end
  end

  always_comb begin
    item_d     = item_q;
    slot_d     = slot_q;
    node_d     = node_q;
    lnode_d    = lnode_q;
    clr_d      = clr_q + 1'b1;
    res_v_d    = 1'b0;
    res_id_d   = res_id_q;
    res_load_d = res_load_q;
    res_bad_d  = res_bad_q;
    pop_o      = 1'b0;
    heap_we    = 1'b0;
    slot_we    = 1'b0;
    heap_waddr = slot_q;
    heap_wdata = node_q;
    slot_waddr = node_q.id;
    slot_wdata = slot_q;
    heap_raddr = '0;
    slot_raddr = id_ext[IW-1:0];
    case (state_q)
      lls_pkg::ST_CLEAR: begin
        heap_we         = 1'b1;
        slot_we         = 1'b1;
        heap_waddr      = clr_q;
        heap_wdata.id   = clr_q;
        heap_wdata.load = '0;
        slot_waddr      = clr_q;
        slot_wdata      = clr_q;
      end
      lls_pkg::ST_IDLE: begin
        pop_o      = !queue_i.empty;
        item_d     = queue_i.head;
        slot_raddr = head_ext[IW-1:0];
      end
      lls_pkg::ST_SLOT: begin
        slot_d     = slot_rdata;
        heap_raddr = slot_rdata;
      end
      lls_pkg::ST_NODE: begin
        node_d = upd;
        if (item_q.dir != lls_pkg::DIR_NONE) begin
          heap_we    = 1'b1;
          heap_wdata = upd;
        end
      end
      lls_pkg::ST_UP_RD: begin
        heap_raddr = p_idx;
      end
      lls_pkg::ST_UP_CMP: begin
        if (precedes(node_q, heap_rdata)) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          slot_we    = 1'b1;
          slot_waddr = heap_rdata.id;
          slot_d     = p_idx;
        end
      end
      lls_pkg::ST_DN_L: begin
        heap_raddr = l_idx[IW-1:0];
      end
      lls_pkg::ST_DN_R: begin
        lnode_d    = heap_rdata;
        heap_raddr = r_idx[IW-1:0];
      end
      lls_pkg::ST_DN_CMP: begin
        if (!best_self) begin
          heap_we    = 1'b1;
          heap_wdata = best_n;
          slot_we    = 1'b1;
          slot_waddr = best_n.id;
          slot_d     = best_i;
        end
      end
      lls_pkg::ST_PLACE: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
      end
      lls_pkg::ST_ROOT: begin
        heap_raddr = '0;
      end
      lls_pkg::ST_OUT: begin
        res_v_d    = 1'b1;
        res_id_d   = root_ext[lls_pkg::IdW-1:0];
        res_load_d = heap_rdata.load;
        res_bad_d  = item_q.bad;
      end
      default: begin
      end
    endcase
    if (cfg_wr_i) begin
      clr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lls_pkg::ST_CLEAR;
      clr_q   <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    slot_q     <= slot_d;
    node_q     <= node_d;
    lnode_q    <= lnode_d;
    res_id_q   <= res_id_d;
    res_load_q <= res_load_d;
    res_bad_q  <= res_bad_d;
  end

  assign clearing_o     = (state_q == lls_pkg::ST_CLEAR);
  assign result_valid_o = res_v_q;
  assign least_id_o     = res_id_q;
  assign least_load_o   = res_load_q;
  assign bad_id_o       = res_bad_q;

endmodule

FILE: sim/tb_least_loaded_server_selector.sv
// Testbench of the least-loaded server selector: load updates checked against a heap predictor.
`timescale 1ns / 100ps
module tb_least_loaded_server_selector;

  typedef struct {
    logic [lls_pkg::IdW-1:0]   id;
    logic [lls_pkg::LoadW-1:0] load;
    logic                      bad;
  } least_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [lls_pkg::IdW-1:0] server_id_i = '0;
  logic [lls_pkg::DeltaW-1:0] load_delta_i = '0;
  logic result_valid_o;
  logic [lls_pkg::IdW-1:0] least_id_o;
  logic [lls_pkg::LoadW-1:0] least_load_o;
  logic bad_id_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [lls_pkg::CfgW-1:0] cfg_data_i = '0;

  least_loaded_server_selector dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  int heap_id [64];
  int heap_load [64];
  int slot_of [64];
  int active_count;
  least_t least_q[$];
  int mismatches;
  int idle_pct;
  int stall_cycles;
  bit timed_out;

  function automatic bit ahead(int a, int b);
    if (heap_load[a] != heap_load[b]) return heap_load[a] < heap_load[b];
    return heap_id[a] < heap_id[b];
  endfunction

  function automatic void swap_nodes(int a, int b);
    int ti, tl;
    ti = heap_id[a]; tl = heap_load[a];
    heap_id[a] = heap_id[b]; heap_load[a] = heap_load[b];
    heap_id[b] = ti; heap_load[b] = tl;
    slot_of[heap_id[a]] = a;
    slot_of[heap_id[b]] = b;
  endfunction

  function automatic void clear_loads(int count);
    int c;
    c = count & 127;
    if (c < 1) c = 1;
    if (c > 64) c = 64;
    active_count = c;
    for (int k = 0; k < 64; k++) begin
      heap_id[k] = k; heap_load[k] = 0; slot_of[k] = k;
    end
  endfunction

  function automatic least_t apply_delta(int id, logic signed [lls_pkg::DeltaW-1:0] delta);
    least_t r;
    longint sum;
    int s, p, l, best;
    r.bad = id >= active_count;
    if (!r.bad) begin
      s = slot_of[id];
      sum = longint'(heap_load[s]) + longint'(delta);
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      heap_load[s] = int'(sum);
      if (delta < 0) begin
        while (s > 0) begin
          p = (s - 1) / 2;
          if (!ahead(s, p)) break;
          swap_nodes(s, p);
          s = p;
        end
      end else if (delta > 0) begin
        forever begin
          l = 2 * s + 1;
          best = s;
          if (l < active_count && ahead(l, best)) best = l;
          if (l + 1 < active_count && ahead(l + 1, best)) best = l + 1;
          if (best == s) break;
          swap_nodes(s, best);
          s = best;
        end
      end
    end
    r.id = lls_pkg::IdW'(heap_id[0]);
    r.load = lls_pkg::LoadW'(heap_load[0]);
    return r;
  endfunction

  always @(posedge clk_i) begin
    least_t e;
    if (result_valid_o) begin
      if (least_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result id=%0d load=%0d", least_id_o,
                                        $signed(least_load_o));
      end else begin
        e = least_q.pop_front();
        if (e.id !== least_id_o || e.load !== least_load_o || e.bad !== bad_id_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected id=%0d load=%0d bad=%0b, got id=%0d load=%0d bad=%0b",
                     e.id, $signed(e.load), e.bad, least_id_o, $signed(least_load_o),
                     bad_id_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 20000 && !timed_out) begin
      timed_out = 1'b1;
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(int id, int delta);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    server_id_i <= id[lls_pkg::IdW-1:0];
    load_delta_i <= delta[lls_pkg::DeltaW-1:0];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    least_q.push_back(apply_delta(id, delta[lls_pkg::DeltaW-1:0]));
  endtask

  task automatic write_count(int value);
    start <= 1'b0;
    while (least_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value[lls_pkg::CfgW-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    clear_loads(value);
  endtask

  task automatic test_extremes();
    send_item(0, 0);
    send_item(63, -32768);
    send_item(63, 32767);
    send_item(5, -1);
    send_item(5, 1);
    send_item(64 - 1, 0);
    for (int k = 0; k < 8; k++) send_item(1, -32768);
    write_count(3);
    send_item(3, 5);
    send_item(63, -7);
    send_item(2, -32768);
    send_item(1, -32768);
    send_item(0, 0);
    write_count(1);
    send_item(0, 32767);
    send_item(1, -3);
    write_count(0);
    send_item(0, -100);
    send_item(1, 100);
    write_count(127);
    send_item(40, -9);
  endtask

  task automatic test_saturation();
    write_count(2);
    for (int k = 0; k < 70000; k++) begin
      if (k % 1000 == 0) send_item(0, 32767);
      else begin
        k += 999;
        send_item(0, 32767);
      end
      if (k > 140000) break;
    end
    for (int k = 0; k < 140; k++) send_item(1, -32768);
    send_item(1, 32767);
  endtask

  task automatic test_random(int n, int count);
    int id, d;
    write_count(count);
    for (int k = 0; k < n; k++) begin
      id = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(active_count - 1);
      case ($urandom_range(5))
        0: d = 0;
        1: d = $urandom_range(1) ? 32767 : -32768;
        2: d = int'($urandom_range(65535)) - 32768;
        default: d = int'($urandom_range(200)) - 100;
      endcase
      send_item(id, d);
    end
  endtask

  initial begin
    mismatches = 0;
    stall_cycles = 0;
    timed_out = 1'b0;
    idle_pct = 8;
    clear_loads(lls_pkg::CfgReset);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_saturation();
    test_random(350, 64);
    idle_pct = 67;
    test_random(250, 17);
    idle_pct = 0;
    test_random(200, 7);
    test_random(150, 64);
    start <= 1'b0;
    while (least_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && least_q.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
